### design/sbha_pkg.sv
package sbha_pkg;

    localparam int BIN_COUNT = 512;

    localparam int IDX_W  = 9;
    localparam int AMP_W  = 16;
    localparam int TIME_W = 16;
    localparam int CNT_W  = 16;
    localparam int WGT_W  = 8;
    localparam int RT_W   = 18;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 32;
    localparam int M_USER_W = 2;

    // count store is kept in rows so that each row has one valid flop
    localparam int SEL_W       = ($clog2(BIN_COUNT) > 9) ? $clog2(BIN_COUNT) - 8 : 1;
    localparam int ROW_ENTRIES = 2 ** SEL_W;
    localparam int ROWS        = (BIN_COUNT + ROW_ENTRIES - 1) / ROW_ENTRIES;
    localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int EXT_W       = (IDX_W > SEL_W + ROW_W) ? IDX_W : SEL_W + ROW_W;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_WEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP_THRESHOLD = 2'd2;

    localparam logic [TIME_W-1:0] WINDOW_LENGTH_RST = 16'd20;
    localparam logic [WGT_W-1:0]  HIT_WEIGHT_RST    = 8'd3;
    localparam logic [AMP_W-1:0]  AMP_THRESHOLD_RST = 16'd80;

    localparam logic signed [RT_W:0] RT_MAX_X = (2 ** (RT_W - 1)) - 1;
    localparam logic signed [RT_W:0] RT_MIN_X = -(2 ** (RT_W - 1));

    typedef logic [ROW_ENTRIES-1:0][CNT_W-1:0] cnt_row_t;

    function automatic logic signed [RT_W-1:0] clamp_rt(input logic signed [RT_W:0] v);
        logic signed [RT_W:0] r;
        if (v > RT_MAX_X) begin
            r = RT_MAX_X;
        end else if (v < RT_MIN_X) begin
            r = RT_MIN_X;
        end else begin
            r = v;
        end
        return r[RT_W-1:0];
    endfunction

endpackage

### design/spectral_bin_hit_accumulator_core.sv
// channel   direction  handshake                 payload
// s_        in         s_tvalid / s_tready       tdata: amplitude, bin_index, elapsed_time
//                                                tuser: first_of_frame
// m_        out        m_tvalid / m_tready       tdata: bin_count, peak_count
//                                                tuser: is_hit, window_opened
// cfg_      in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one beat per cycle in and out while m_tready holds; a beat passes the middle stage and
// then the result register before it is offered, the count store read being registered.
// a row read issued in the same cycle as a write to that row takes the written row
// from a forward register. reset clears the row valid flags at once, so the store
// needs no clearing pass and a new window clears them all together. a stalled result
// holds the middle stage, which still takes a beat whenever the result register moves on.
module spectral_bin_hit_accumulator_core (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    // amplitude [15:0], bin_index [24:16], elapsed_time [40:25], zero [47:41]
    input  logic [sbha_pkg::S_DATA_W-1:0]     s_tdata,
    // first_of_frame [0]
    input  logic                              s_tuser,

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // bin_count [15:0], peak_count [31:16]
    output logic [sbha_pkg::M_DATA_W-1:0]     m_tdata,
    // is_hit [0], window_opened [1]
    output logic [sbha_pkg::M_USER_W-1:0]     m_tuser,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sbha_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sbha_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CNT_W = sbha_pkg::CNT_W;
    localparam int RT_W  = sbha_pkg::RT_W;
    localparam int EXT_W = sbha_pkg::EXT_W;
    localparam int SEL_W = sbha_pkg::SEL_W;
    localparam int ROW_W = sbha_pkg::ROW_W;
    localparam logic [EXT_W:0] BIN_LIMIT = (EXT_W + 1)'(sbha_pkg::BIN_COUNT);

    // configuration
    logic [sbha_pkg::TIME_W-1:0] window_length_reg;
    logic [sbha_pkg::WGT_W-1:0]  hit_weight_reg;
    logic [sbha_pkg::AMP_W-1:0]  amp_threshold_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= sbha_pkg::WINDOW_LENGTH_RST;
            hit_weight_reg    <= sbha_pkg::HIT_WEIGHT_RST;
            amp_threshold_reg <= sbha_pkg::AMP_THRESHOLD_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                sbha_pkg::CFG_WINDOW_LENGTH: window_length_reg <= cfg_data;
                sbha_pkg::CFG_HIT_WEIGHT:    hit_weight_reg    <= cfg_data[sbha_pkg::WGT_W-1:0];
                sbha_pkg::CFG_AMP_THRESHOLD: amp_threshold_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // handshake
    logic p1_valid_reg;
    logic m_valid_reg;
    logic adv;
    logic s_beat;

    assign adv      = p1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !p1_valid_reg || adv;
    assign s_beat   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;

    // input side address
    logic [EXT_W-1:0] s_bin_ext;
    logic [ROW_W-1:0] s_row;

    assign s_bin_ext = EXT_W'(s_tdata[24:16]);
    assign s_row     = s_bin_ext[SEL_W +: ROW_W];

    // middle stage
    logic [sbha_pkg::AMP_W-1:0]  p1_amp_reg;
    logic [EXT_W-1:0]            p1_bin_reg;
    logic                        p1_first_reg;
    logic [sbha_pkg::TIME_W-1:0] p1_elapsed_reg;
    logic                        p1_fwd_reg;
    sbha_pkg::cnt_row_t          p1_fwd_data_reg;
    sbha_pkg::cnt_row_t          rdata_reg;

    // window state
    logic signed [RT_W-1:0] rt_reg;
    logic signed [RT_W-1:0] rt_next;
    logic [CNT_W-1:0]       peak_reg;
    logic [CNT_W-1:0]       peak_next;
    logic [sbha_pkg::ROWS-1:0] row_valid_reg;
    logic [sbha_pkg::ROWS-1:0] row_valid_next;

    sbha_pkg::cnt_row_t mem [sbha_pkg::ROWS];

    // processing
    logic [ROW_W-1:0]       p1_row;
    logic [SEL_W-1:0]       p1_sel;
    logic                   in_range;
    logic signed [RT_W:0]   rt_sub;
    logic signed [RT_W-1:0] rt_a;
    logic signed [RT_W:0]   rt_add;
    logic                   opened;
    logic                   hit;
    sbha_pkg::cnt_row_t     row_base;
    sbha_pkg::cnt_row_t     row_upd;
    logic [CNT_W-1:0]       entry;
    logic [CNT_W:0]         sum;
    logic [CNT_W-1:0]       cnt_upd;
    logic [CNT_W-1:0]       peak_base;
    logic [CNT_W-1:0]       count_out;
    logic                   wr_en;

    assign p1_row   = p1_bin_reg[SEL_W +: ROW_W];
    assign p1_sel   = p1_bin_reg[SEL_W-1:0];
    assign in_range = {1'b0, p1_bin_reg} < BIN_LIMIT;

    always_comb begin
        rt_sub = {rt_reg[RT_W-1], rt_reg} - $signed({3'b000, p1_elapsed_reg});
        rt_a   = sbha_pkg::clamp_rt(rt_sub);
        rt_add = {rt_a[RT_W-1], rt_a} + $signed({3'b000, window_length_reg});
        opened = p1_first_reg && (rt_a <= 0);
        if (!p1_first_reg) begin
            rt_next = rt_reg;
        end else if (opened) begin
            rt_next = sbha_pkg::clamp_rt(rt_add);
        end else begin
            rt_next = rt_a;
        end

        hit = p1_amp_reg >= amp_threshold_reg;

        if (opened || !row_valid_reg[p1_row]) begin
            row_base = '0;
        end else if (p1_fwd_reg) begin
            row_base = p1_fwd_data_reg;
        end else begin
            row_base = rdata_reg;
        end
        entry = row_base[p1_sel];

        sum     = {1'b0, entry} + (CNT_W + 1)'(hit_weight_reg);
        cnt_upd = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];

        row_upd         = row_base;
        row_upd[p1_sel] = cnt_upd;

        peak_base = opened ? '0 : peak_reg;
        wr_en     = adv && in_range && hit;

        if (!in_range) begin
            count_out = '0;
        end else if (hit) begin
            count_out = cnt_upd;
        end else begin
            count_out = entry;
        end

        if (in_range && hit && (cnt_upd > peak_base)) begin
            peak_next = cnt_upd;
        end else begin
            peak_next = peak_base;
        end

        row_valid_next = opened ? '0 : row_valid_reg;
        if (in_range && hit) begin
            row_valid_next[p1_row] = 1'b1;
        end
    end

    // count store
    always_ff @(posedge aclk) begin
        if (s_beat) begin
            rdata_reg <= mem[s_row];
        end
        if (wr_en) begin
            mem[p1_row] <= row_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            rt_reg        <= '0;
            peak_reg      <= '0;
            row_valid_reg <= '0;
        end else begin
            if (s_beat) begin
                p1_valid_reg <= 1'b1;
            end else if (adv) begin
                p1_valid_reg <= 1'b0;
            end
            if (adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (adv) begin
                rt_reg        <= rt_next;
                peak_reg      <= peak_next;
                row_valid_reg <= row_valid_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            p1_amp_reg      <= s_tdata[15:0];
            p1_bin_reg      <= s_bin_ext;
            p1_first_reg    <= s_tuser;
            p1_elapsed_reg  <= s_tdata[40:25];
            p1_fwd_reg      <= wr_en && (p1_row == s_row);
            p1_fwd_data_reg <= row_upd;
        end
        if (adv) begin
            m_tdata <= {peak_next, count_out};
            m_tuser <= {opened, hit};
        end
    end

endmodule
